// ===== hw/rtl/cepstral_delta_double_delta_assert.svh =====
// Assertion macros shared by the cepstral delta RTL.
`ifndef CEPSTRAL_DELTA_DOUBLE_DELTA_ASSERT_SVH
`define CEPSTRAL_DELTA_DOUBLE_DELTA_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CDDD_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Next-cycle implication.
`define CDDD_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define CDDD_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define CDDD_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif

`endif

// ===== hw/rtl/cddd_pkg.sv =====
// Shared types and constants of the cepstral delta / double delta block.
`default_nettype none
package cddd_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int CIDX_W        = 4;
    localparam int MAX_COEFS_DEF = 15;
    localparam int MAX_HALF_DEF  = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COEFS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_WINDOW = 1'b1;

    localparam logic [3:0] NUM_COEFS_RST    = 4'd13;
    localparam logic [1:0] DELTA_WINDOW_RST = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] coef_value;
        logic                       utterance_end;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] static_out;
        logic signed [SAMPLE_W-1:0] delta_out;
        logic signed [SAMPLE_W-1:0] double_delta_out;
        logic [CIDX_W-1:0]          coef_index;
        logic                       frame_last;
        logic                       run_last;
    } result_t;

    typedef struct packed {
        logic              shift;
        logic              wr_stat;
        logic              wr_dlt;
        logic [CIDX_W-1:0] idx;
    } cell_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DL,
        S_DLW,
        S_EMCHK,
        S_POST,
        S_TERM,
        S_TW,
        S_DD,
        S_DDW,
        S_PUT,
        S_FIN
    } seq_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cddd_cell.sv =====
// One frame cell: statics and deltas of a frame, rotated along the ring.
`default_nettype none
module cddd_cell #(
    parameter int MAX_COEFS = cddd_pkg::MAX_COEFS_DEF
) (
    input  wire                                  clk,
    input  wire cddd_pkg::cell_ctl_t             ctl,
    input  wire logic signed [cddd_pkg::SAMPLE_W-1:0] wr_data,
    input  wire logic signed [cddd_pkg::SAMPLE_W-1:0] shift_stat [MAX_COEFS],
    input  wire logic signed [cddd_pkg::SAMPLE_W-1:0] shift_dlt  [MAX_COEFS],
    output logic signed [cddd_pkg::SAMPLE_W-1:0]      frame_stat [MAX_COEFS],
    output logic signed [cddd_pkg::SAMPLE_W-1:0]      frame_dlt  [MAX_COEFS],
    output logic signed [cddd_pkg::SAMPLE_W-1:0]      rd_stat,
    output logic signed [cddd_pkg::SAMPLE_W-1:0]      rd_dlt
);
    import cddd_pkg::*;

    localparam int IW = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;

    logic signed [SAMPLE_W-1:0] stat_reg [MAX_COEFS];
    logic signed [SAMPLE_W-1:0] dlt_reg  [MAX_COEFS];

    // Hand the whole frame to the neighbor on a rotate, else write one entry.
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            stat_reg <= shift_stat;
            dlt_reg  <= shift_dlt;
        end
        else
        begin
            if (ctl.wr_stat)
            begin
                stat_reg[ctl.idx[IW-1:0]] <= wr_data;
            end
            if (ctl.wr_dlt)
            begin
                dlt_reg[ctl.idx[IW-1:0]] <= wr_data;
            end
        end
    end

    assign frame_stat = stat_reg;
    assign frame_dlt  = dlt_reg;
    assign rd_stat    = stat_reg[ctl.idx[IW-1:0]];
    assign rd_dlt     = dlt_reg[ctl.idx[IW-1:0]];

endmodule
`default_nettype wire

// ===== hw/rtl/cddd_div.sv =====
// Rounding divider by the regression normalizer (4 or 20), saturating.
`default_nettype none
module cddd_div (
    input  wire                                       clk,
    input  wire                                       rst_n,
    input  wire                                       go,
    input  wire                                       n2,
    input  wire logic signed [cddd_pkg::SAMPLE_W+3:0] num,
    output logic                                      done,
    output logic signed [cddd_pkg::SAMPLE_W-1:0]      res
);
    import cddd_pkg::*;

    localparam int NW = SAMPLE_W + 4;
    localparam int S  = SAMPLE_W + 9;
    localparam int PW = NW + S;
    localparam longint unsigned KVAL = ((64'd1 << S) + 64'd19) / 64'd20;
    localparam logic [PW-1:0] K = PW'(KVAL);
    localparam logic [NW-1:0] RND20 = NW'(10);
    localparam logic [NW-1:0] RND4  = NW'(2);
    localparam logic signed [NW:0] HI_X = (NW+1)'((64'sd1 <<< (SAMPLE_W-1)) - 64'sd1);
    localparam logic signed [NW:0] LO_X = -HI_X - (NW+1)'(1);

    logic          v1_reg, v2_reg;
    logic          neg1_reg, n21_reg, neg2_reg;
    logic [NW-1:0] mag1_reg;
    logic [PW-1:0] prod_reg;

    logic [NW-1:0]        mag_next;
    logic [PW-1:0]        prod_next;
    logic [NW-1:0]        q;
    logic signed [NW:0]   sq;

    always_comb
    begin
        mag_next  = (num[NW-1] ? NW'(-num) : NW'(num)) + (n2 ? RND20 : RND4);
        // Divide by 20 through the reciprocal, by 4 through a plain shift.
        prod_next = n21_reg ? (PW'(mag1_reg) * K) : (PW'(mag1_reg) << (S - 2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= go;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            mag1_reg <= mag_next;
            neg1_reg <= num[NW-1];
            n21_reg  <= n2;
        end
        if (v1_reg)
        begin
            prod_reg <= prod_next;
            neg2_reg <= neg1_reg;
        end
    end

    always_comb
    begin
        q  = prod_reg[PW-1:S];
        sq = neg2_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (sq > HI_X)
        begin
            res = HI_X[SAMPLE_W-1:0];
        end
        else if (sq < LO_X)
        begin
            res = LO_X[SAMPLE_W-1:0];
        end
        else
        begin
            res = sq[SAMPLE_W-1:0];
        end
    end

    assign done = v2_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/cepstral_delta_double_delta.sv =====
// Top level: streaming cepstral delta and double delta regression over a ring of frame cells.
//
//  channel    | signals                               | direction | moves
//  -----------+---------------------------------------+-----------+-----------------------
//  sample     | sample_valid, sample_ready, sample    | in        | one coefficient request
//  result     | result_valid, result_ready, result    | out       | static, delta, ddelta
//  cfg        | cfg_valid, cfg_ready, cfg_index/data  | in        | register write
//
//  Work: a request that causes no result stores its static, plus its delta once that is due
//  (one divider use); one that emits a result also runs the term sequencer and the shared
//  rounding divider. A flush runs the term sequencer and the divider again for each flushed
//  result.
//  Reset clears the sequencer and counters and sets config to its reset values; frame cells hold garbage until written.
//  A stalled result holds in the output register; the sequencer waits there before loading
//  another, and returns to accept the next request while the last result waits.
//  cfg_ready is always high.
`default_nettype none
`include "cepstral_delta_double_delta_assert.svh"
module cepstral_delta_double_delta #(
    parameter int MAX_COEFS      = cddd_pkg::MAX_COEFS_DEF,
    parameter int MAX_HALF_WIDTH = cddd_pkg::MAX_HALF_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   sample_valid,
    output logic                                  sample_ready,
    input  wire cddd_pkg::sample_t                sample,
    output logic                                  result_valid,
    input  wire                                   result_ready,
    output cddd_pkg::result_t                     result,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cddd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cddd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cddd_pkg::*;

    localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;       // frames held in the ring
    localparam int SW    = $clog2(DEPTH);
    localparam int BW    = $clog2(3 * MAX_HALF_WIDTH + 1); // back distance incl. aliasing
    localparam int NW    = SAMPLE_W + 4;

    // ---------------- configuration ----------------
    logic [3:0] num_coefs_reg;
    logic [1:0] delta_window_reg;
    logic [3:0] k_eff;
    logic [1:0] n_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_coefs_reg    <= NUM_COEFS_RST;
            delta_window_reg <= DELTA_WINDOW_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NUM_COEFS:    num_coefs_reg    <= cfg_data[3:0];
                CFG_DELTA_WINDOW: delta_window_reg <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    // Zero counts as one; clamp to what the ring and cells can hold.
    always_comb
    begin
        if (num_coefs_reg == 4'd0)
        begin
            k_eff = 4'd1;
        end
        else if (32'(num_coefs_reg) > MAX_COEFS)
        begin
            k_eff = 4'(MAX_COEFS);
        end
        else
        begin
            k_eff = num_coefs_reg;
        end
        if (delta_window_reg == 2'd0)
        begin
            n_eff = 2'd1;
        end
        else if (32'(delta_window_reg) > MAX_HALF_WIDTH)
        begin
            n_eff = 2'(MAX_HALF_WIDTH);
        end
        else
        begin
            n_eff = delta_window_reg;
        end
    end

    // ---------------- state ----------------
    seq_state_t state_reg, state_next;
    logic [3:0] coef_reg, coef_next;
    logic [3:0] frames_reg, frames_next;
    logic [3:0] cur_c_reg, cur_c_next;
    logic       flush_reg, flush_next;
    logic       last_reg, last_next;
    logic       flushing_reg, flushing_next;
    logic [BW-1:0] b_reg, b_next;
    logic [2:0] term_reg, term_next;
    logic signed [NW-1:0]       acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0] d_reg, d_next;
    logic signed [SAMPLE_W-1:0] dd_reg, dd_next;
    logic    result_valid_reg;
    result_t result_reg, result_next;

    // ---------------- cell ring ----------------
    cell_ctl_t cell_ctl [DEPTH];
    logic signed [SAMPLE_W-1:0] wr_data;
    logic signed [SAMPLE_W-1:0] fr_stat [DEPTH][MAX_COEFS];
    logic signed [SAMPLE_W-1:0] fr_dlt  [DEPTH][MAX_COEFS];
    logic signed [SAMPLE_W-1:0] sv [DEPTH];
    logic signed [SAMPLE_W-1:0] dv [DEPTH];
    logic signed [NW-1:0]       sv_x [DEPTH];
    logic wr_stat0, wr_dlt_n, rotate;

    // Cell j holds the frame j back from the newest; rotate moves each frame one back
    // and brings the oldest around to the front, where it is overwritten entry by entry.
    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        localparam int PREV = (j == 0) ? DEPTH - 1 : j - 1;

        always_comb
        begin
            cell_ctl[j].idx     = cur_c_reg;
            cell_ctl[j].shift   = rotate;
            cell_ctl[j].wr_stat = wr_stat0 && (j == 0);
            cell_ctl[j].wr_dlt  = wr_dlt_n && (32'(n_eff) == j);
        end

        cddd_cell #(
            .MAX_COEFS (MAX_COEFS)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl[j]),
            .wr_data    (wr_data),
            .shift_stat (fr_stat[PREV]),
            .shift_dlt  (fr_dlt[PREV]),
            .frame_stat (fr_stat[j]),
            .frame_dlt  (fr_dlt[j]),
            .rd_stat    (sv[j]),
            .rd_dlt     (dv[j])
        );

        assign sv_x[j] = NW'(sv[j]);
    end

    // ---------------- shared divider ----------------
    logic                       div_go, div_done;
    logic signed [NW-1:0]       div_num;
    logic signed [SAMPLE_W-1:0] div_res;

    cddd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .n2    (n_eff == 2'd2),
        .num   (div_num),
        .done  (div_done),
        .res   (div_res)
    );

    // Back distance to ring slot; distances past the ring wrap onto the front.
    function automatic logic [SW-1:0] slot_of(input logic [BW-1:0] back);
        slot_of = (32'(back) >= DEPTH) ? SW'(32'(back) - DEPTH) : SW'(back);
    endfunction

    // ---------------- datapath helpers ----------------
    logic [2:0]  n2x;
    logic [4:0]  fx;
    logic        f_ge_n, f_ge_2n, dl_edge, last_c, c_done;
    logic [BW-1:0] top_b;
    logic signed [NW-1:0] dl_num;
    logic [2:0]  m_j;
    logic [BW-1:0] back_j;
    logic        edge_fd, edge_dd;
    logic [2:0]  last_term;
    logic signed [SAMPLE_W-1:0] term_val;
    logic signed [NW-1:0] weighted;
    logic        fin_c;

    always_comb
    begin
        n2x     = {n_eff, 1'b0};
        fx      = {1'b0, frames_reg};
        f_ge_n  = fx >= 5'(n_eff);
        f_ge_2n = fx >= 5'(n2x);
        dl_edge = fx < 5'(n2x);
        last_c  = (5'(coef_reg) + 5'd1) >= 5'(k_eff);
        c_done  = (5'(cur_c_reg) + 5'd1) >= 5'(k_eff);
        fin_c   = (b_reg == '0) && c_done;
        top_b   = (fx < 5'(n2x - 3'd1)) ? BW'(frames_reg) : BW'(n2x - 3'd1);
    end

    // Regression over statics centered on the frame N back.
    always_comb
    begin
        logic [SW-1:0] lo;
        logic [SW-1:0] hi;
        dl_num = '0;
        for (int m = 1; m <= MAX_HALF_WIDTH; m++)
        begin
            lo = SW'(n_eff) - SW'(m);
            hi = SW'(n_eff) + SW'(m);
            if (m <= 32'(n_eff))
            begin
                dl_num = dl_num + (sv_x[lo] - sv_x[hi]) * signed'(NW'(m));
            end
        end
    end

    // Term j of an emit: j = 0 fetches the delta of the frame itself, odd j the frame
    // m later (added), even j the frame m earlier (subtracted).
    always_comb
    begin
        m_j = (term_reg + 3'd1) >> 1;
        if (term_reg == 3'd0)
        begin
            back_j = b_reg;
        end
        else if (term_reg[0])
        begin
            back_j = b_reg - BW'(m_j);
        end
        else
        begin
            back_j = b_reg + BW'(m_j);
        end
        edge_fd   = flushing_reg && ((5'(back_j) > fx) || (fx < 5'(back_j) + 5'(n_eff)) ||
                                     (5'(back_j) < 5'(n_eff)));
        edge_dd   = (fx < 5'(b_reg) + 5'(n_eff)) || (5'(b_reg) < 5'(n_eff));
        last_term = edge_dd ? 3'd0 : n2x;
        term_val  = (state_reg == S_TW) ? div_res : dv[slot_of(back_j)];
        weighted  = NW'(term_val) * signed'(NW'(m_j));
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            coef_reg     <= '0;
            frames_reg   <= '0;
            cur_c_reg    <= '0;
            flush_reg    <= 1'b0;
            last_reg     <= 1'b0;
            flushing_reg <= 1'b0;
            b_reg        <= '0;
            term_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            coef_reg     <= coef_next;
            frames_reg   <= frames_next;
            cur_c_reg    <= cur_c_next;
            flush_reg    <= flush_next;
            last_reg     <= last_next;
            flushing_reg <= flushing_next;
            b_reg        <= b_next;
            term_reg     <= term_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        d_reg   <= d_next;
        dd_reg  <= dd_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        coef_next     = coef_reg;
        frames_next   = frames_reg;
        cur_c_next    = cur_c_reg;
        flush_next    = flush_reg;
        last_next     = last_reg;
        flushing_next = flushing_reg;
        b_next        = b_reg;
        term_next     = term_reg;
        acc_next      = acc_reg;
        d_next        = d_reg;
        dd_next       = dd_reg;
        sample_ready  = 1'b0;
        div_go        = 1'b0;
        div_num       = '0;
        wr_stat0      = 1'b0;
        wr_dlt_n      = 1'b0;
        wr_data       = sample.coef_value;
        rotate        = 1'b0;
        result_next   = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    // Store the static at once; an end flag counts only on a frame's end.
                    wr_stat0   = 1'b1;
                    last_next  = last_c;
                    flush_next = last_c && sample.utterance_end;
                    state_next = f_ge_n ? S_DL : S_POST;
                end
            end
            S_DL:
            begin
                div_go     = 1'b1;
                div_num    = dl_edge ? sv_x[SW'(n_eff)] : dl_num;
                state_next = S_DLW;
            end
            S_DLW:
            begin
                if (div_done)
                begin
                    wr_dlt_n   = 1'b1;
                    wr_data    = div_res;
                    state_next = S_EMCHK;
                end
            end
            S_EMCHK:
            begin
                if (f_ge_2n)
                begin
                    b_next        = BW'(n2x);
                    flushing_next = 1'b0;
                    term_next     = '0;
                    state_next    = S_TERM;
                end
                else
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (flush_reg)
                begin
                    // Drain the pending frames, oldest first.
                    b_next        = top_b;
                    cur_c_next    = '0;
                    flushing_next = 1'b1;
                    term_next     = '0;
                    state_next    = S_TERM;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_TERM, S_TW:
            begin
                if (state_reg == S_TERM && edge_fd)
                begin
                    div_go     = 1'b1;
                    div_num    = sv_x[slot_of(back_j)];
                    state_next = S_TW;
                end
                else if (state_reg == S_TERM || div_done)
                begin
                    if (term_reg == 3'd0)
                    begin
                        d_next   = term_val;
                        acc_next = '0;
                    end
                    else if (term_reg[0])
                    begin
                        acc_next = acc_reg + weighted;
                    end
                    else
                    begin
                        acc_next = acc_reg - weighted;
                    end
                    if (term_reg == last_term)
                    begin
                        state_next = S_DD;
                    end
                    else
                    begin
                        term_next  = term_reg + 3'd1;
                        state_next = S_TERM;
                    end
                end
            end
            S_DD:
            begin
                div_go     = 1'b1;
                div_num    = edge_dd ? sv_x[slot_of(b_reg)] : acc_reg;
                state_next = S_DDW;
            end
            S_DDW:
            begin
                if (div_done)
                begin
                    dd_next    = div_res;
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.static_out       = sv[slot_of(b_reg)];
                    result_next.delta_out        = d_reg;
                    result_next.double_delta_out = dd_reg;
                    result_next.coef_index       = cur_c_reg;
                    result_next.frame_last       = flushing_reg && fin_c;
                    result_next.run_last         = flushing_reg ? fin_c : !flush_reg;
                    term_next                    = '0;
                    if (!flushing_reg)
                    begin
                        state_next = S_POST;
                    end
                    else if (!c_done)
                    begin
                        cur_c_next = cur_c_reg + 4'd1;
                        state_next = S_TERM;
                    end
                    else if (b_reg != '0)
                    begin
                        b_next     = b_reg - BW'(1);
                        cur_c_next = '0;
                        state_next = S_TERM;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (flush_reg)
                begin
                    coef_next   = '0;
                    cur_c_next  = '0;
                    frames_next = '0;
                end
                else if (last_reg)
                begin
                    // Frame complete: advance the ring, count frames up to saturation.
                    rotate      = 1'b1;
                    coef_next   = '0;
                    cur_c_next  = '0;
                    frames_next = (frames_reg != 4'hF) ? frames_reg + 4'd1 : frames_reg;
                end
                else
                begin
                    coef_next  = coef_reg + 4'd1;
                    cur_c_next = coef_reg + 4'd1;
                end
                flushing_next = 1'b0;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- output register ----------------
    logic out_load;
    assign out_load = (state_reg == S_PUT) && (!result_valid_reg || result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- checks ----------------
    `CDDD_ASSERT_IMP(a_load_free, clk, rst_n, out_load, (!result_valid_reg || result_ready))
    `CDDD_ASSERT_NXT(a_accept_busy, clk, rst_n, (sample_valid && sample_ready), (state_reg != S_IDLE))
    `CDDD_ASSERT_NXT(a_flush_clear, clk, rst_n, (state_reg == S_FIN && flush_reg), (frames_reg == 4'd0 && coef_reg == 4'd0))
    `CDDD_ASSERT_IMP(a_idle_index, clk, rst_n, (state_reg == S_IDLE), (cur_c_reg == coef_reg))

endmodule
`default_nettype wire
